>>> hw/rtl/grs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grs_pkg
// Shared types, constants and row functions of the glyph row styler: style
// codes, register indexes, accent glyph tables and the row restyle and
// accent patch functions.
// ----------------------------------------------------------------------------
package grs_pkg;

    localparam int ROWS_PER_GLYPH = 16;
    localparam int GLYPH_TOTAL    = 256;
    localparam int ACCENT_GLYPHS  = 12;

    localparam int GLYPH_W      = $clog2(GLYPH_TOTAL);
    localparam int ROW_W        = $clog2(ROWS_PER_GLYPH);
    localparam int BITS_W       = 8;
    localparam int ACCENT_IDX_W = $clog2(ACCENT_GLYPHS);
    localparam int STORE_DEPTH  = ACCENT_GLYPHS * ROWS_PER_GLYPH;
    localparam int STORE_AW     = ACCENT_IDX_W + ROW_W;

    localparam int STYLE_W = 4;
    localparam int CFG_W   = STYLE_W;

    localparam int EMIT_DEPTH = 4;

    localparam logic [ROW_W-1:0] LAST_ROW      = ROW_W'(ROWS_PER_GLYPH - 1);
    localparam logic [ROW_W-1:0] UNDERLINE_ROW = 4'd14;
    localparam logic [ROW_W-1:0] STRIKE_ROW    = 4'd8;

    // Register indexes
    localparam logic [0:0] REG_STYLE   = 1'b0;
    localparam logic [0:0] REG_TURKISH = 1'b1;

    // Style codes
    localparam logic [STYLE_W-1:0] STYLE_DEFAULT   = 4'd0;
    localparam logic [STYLE_W-1:0] STYLE_BOLD      = 4'd1;
    localparam logic [STYLE_W-1:0] STYLE_NARROW    = 4'd2;
    localparam logic [STYLE_W-1:0] STYLE_ITALIC    = 4'd3;
    localparam logic [STYLE_W-1:0] STYLE_UNDERLINE = 4'd4;
    localparam logic [STYLE_W-1:0] STYLE_STRIKE    = 4'd5;
    localparam logic [STYLE_W-1:0] STYLE_WIDE      = 4'd6;
    localparam logic [STYLE_W-1:0] STYLE_OUTLINE   = 4'd7;
    localparam logic [STYLE_W-1:0] STYLE_SHADOW    = 4'd8;
    localparam logic [STYLE_W-1:0] STYLE_RETRO     = 4'd9;

    typedef enum logic [2:0] {
        PATCH_CEDILLA = 3'd0,
        PATCH_BREVE   = 3'd1,
        PATCH_DOTLESS = 3'd2,
        PATCH_DOT     = 3'd3,
        PATCH_UMLAUT  = 3'd4
    } patch_kind_t;

    localparam logic [GLYPH_W-1:0] SRC_CODE [ACCENT_GLYPHS] = '{
        8'h63, 8'h43, 8'h67, 8'h47, 8'h69, 8'h49,
        8'h6F, 8'h4F, 8'h73, 8'h53, 8'h75, 8'h55
    };

    localparam logic [GLYPH_W-1:0] DST_CODE [ACCENT_GLYPHS] = '{
        8'hE7, 8'hC7, 8'hF0, 8'hD0, 8'hFD, 8'hDD,
        8'hF6, 8'hD6, 8'hFE, 8'hDE, 8'hFC, 8'hDC
    };

    localparam patch_kind_t PATCH_KIND [ACCENT_GLYPHS] = '{
        PATCH_CEDILLA, PATCH_CEDILLA, PATCH_BREVE, PATCH_BREVE,
        PATCH_DOTLESS, PATCH_DOT, PATCH_UMLAUT, PATCH_UMLAUT,
        PATCH_CEDILLA, PATCH_CEDILLA, PATCH_UMLAUT, PATCH_UMLAUT
    };

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph_code;
        logic [ROW_W-1:0]   row_index;
        logic [BITS_W-1:0]  row_bits;
    } row_item_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] out_glyph;
        logic [ROW_W-1:0]   out_row;
        logic [BITS_W-1:0]  out_bits;
        logic               run_last;
    } styled_item_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [ROW_W-1:0]   row;
        logic [BITS_W-1:0]  bits;
        logic               last;
    } emit_t;

    typedef struct packed {
        logic                    hit;
        logic [ACCENT_IDX_W-1:0] idx;
        patch_kind_t             kind;
    } accent_hit_t;

    function automatic logic [BITS_W-1:0] style_row(
        input logic [STYLE_W-1:0] sel,
        input logic [ROW_W-1:0]   r,
        input logic [BITS_W-1:0]  b,
        input logic [BITS_W-1:0]  prev,
        input logic [BITS_W-1:0]  next
    );
        logic [BITS_W-1:0] v;
        case (sel)
            STYLE_BOLD:      v = b | (b >> 1);
            STYLE_NARROW:    v = b & 8'hFE;
            STYLE_ITALIC:
            begin
                if (r < 4'd4)
                    v = b >> 1;
                else if (r >= 4'd12)
                    v = b << 1;
                else
                    v = b;
            end
            STYLE_UNDERLINE: v = (r == UNDERLINE_ROW) ? 8'hFF : b;
            STYLE_STRIKE:    v = (r == STRIKE_ROW) ? 8'hFF : b;
            STYLE_WIDE:      v = b | (b >> 1) | (b << 1);
            STYLE_OUTLINE:   v = b & ~(b << 1) & ~(b >> 1);
            STYLE_SHADOW:    v = b | ((r != '0) ? (prev >> 1) : 8'h00);
            STYLE_RETRO:     v = b | ((r != LAST_ROW) ? next : 8'h00) | (b >> 1);
            default:         v = b;
        endcase
        return v;
    endfunction

    function automatic logic [BITS_W-1:0] patch_row(
        input patch_kind_t       kind,
        input logic [ROW_W-1:0]  r,
        input logic [BITS_W-1:0] v
    );
        logic [BITS_W-1:0] p;
        p = v;
        case (kind)
            PATCH_CEDILLA:
            begin
                if (r == 4'd13)
                    p = 8'h0C;
                else if (r == 4'd14)
                    p = 8'h18;
            end
            PATCH_BREVE:
            begin
                if (r == 4'd1)
                    p = 8'h66;
                else if (r == 4'd2)
                    p = 8'h00;
            end
            PATCH_DOTLESS:
            begin
                if (r == 4'd2)
                    p = 8'h00;
            end
            PATCH_DOT:
            begin
                if (r == 4'd1)
                    p = 8'h18;
                else if (r == 4'd2)
                    p = 8'h00;
            end
            default:
            begin
                if (r == 4'd1)
                    p = 8'h24;
                else if (r == 4'd2)
                    p = 8'h00;
            end
        endcase
        return p;
    endfunction

    function automatic accent_hit_t src_lookup(input logic [GLYPH_W-1:0] g);
        accent_hit_t h;
        h = '0;
        for (int i = 0; i < ACCENT_GLYPHS; i++)
        begin
            if (g == SRC_CODE[i])
            begin
                h.hit  = 1'b1;
                h.idx  = ACCENT_IDX_W'(i);
                h.kind = PATCH_KIND[i];
            end
        end
        return h;
    endfunction

    function automatic accent_hit_t dst_lookup(input logic [GLYPH_W-1:0] g);
        accent_hit_t h;
        h = '0;
        for (int i = 0; i < ACCENT_GLYPHS; i++)
        begin
            if (g == DST_CODE[i])
            begin
                h.hit  = 1'b1;
                h.idx  = ACCENT_IDX_W'(i);
                h.kind = PATCH_KIND[i];
            end
        end
        return h;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/grs_accent_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grs_accent_stage
// Output stage: stores styled rows of the accent source glyphs, reads them
// back for the accented target glyphs when Turkish mode is on, patches
// accent rows and holds the result for the output transfer.
// ----------------------------------------------------------------------------
module grs_accent_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  turkish_enable,
    input  wire logic                  emit_valid,
    input  wire grs_pkg::emit_t        emit_rec,
    output logic                       emit_ready,
    output logic                       styled_valid,
    input  wire logic                  styled_ready,
    output grs_pkg::styled_item_t      styled_data
);
    import grs_pkg::*;

    logic [BITS_W-1:0] store_mem [STORE_DEPTH];

    logic                q_valid_reg;
    logic                q_valid_next;
    emit_t               q_rec_reg;
    logic                q_patch_reg;
    patch_kind_t         q_kind_reg;
    logic [BITS_W-1:0]   rd_data_reg;

    logic                advance;
    logic                take;
    accent_hit_t         src_hit;
    accent_hit_t         dst_hit;
    logic                store_we;
    logic                store_re;
    logic [STORE_AW-1:0] store_addr;

    always_comb
    begin
        advance    = !q_valid_reg || styled_ready;
        take       = advance && emit_valid;
        src_hit    = src_lookup(emit_rec.glyph);
        dst_hit    = dst_lookup(emit_rec.glyph);
        store_we   = take && src_hit.hit;
        store_re   = take && dst_hit.hit && turkish_enable;
        store_addr = src_hit.hit ? {src_hit.idx, emit_rec.row}
                                 : {dst_hit.idx, emit_rec.row};
        q_valid_next = advance ? emit_valid : q_valid_reg;
    end

    assign emit_ready = advance;

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_addr] <= emit_rec.bits;
        if (store_re)
            rd_data_reg <= store_mem[store_addr];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            q_rec_reg   <= emit_rec;
            q_patch_reg <= store_re;
            q_kind_reg  <= dst_hit.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else
            q_valid_reg <= q_valid_next;
    end

    always_comb
    begin
        styled_valid          = q_valid_reg;
        styled_data.out_glyph = q_rec_reg.glyph;
        styled_data.out_row   = q_rec_reg.row;
        styled_data.out_bits  = q_patch_reg
                              ? patch_row(q_kind_reg, q_rec_reg.row, rd_data_reg)
                              : q_rec_reg.bits;
        styled_data.run_last  = q_rec_reg.last;
    end

endmodule
`default_nettype wire

>>> hw/rtl/glyph_row_styler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_row_styler
// Restyles 8x16 font rows one at a time and builds accented glyphs from
// stored styled rows of their Latin source glyphs.
//
//   channel   | signals                                 | moves
//   ----------+-----------------------------------------+---------------------
//   row in    | row_valid, row_ready, row_data          | one base font row
//   styled out| styled_valid, styled_ready, styled_data | one styled row
//   config    | cfg_we, cfg_index, cfg_data             | one register write
//
// One row transfer per cycle while the result queue has room for two
// entries, as a row 15 transfer can push two results; results leave at
// one per cycle while styled_ready is high. Rows other than row 15 wait
// in the held row; all pass the queue and the output register. A stalled
// output fills the queue and then drops row_ready. Reset clears the held
// row, the queue and the output stage; the accent store is not cleared.
// ----------------------------------------------------------------------------
module glyph_row_styler #(
    parameter int EMIT_DEPTH = grs_pkg::EMIT_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [grs_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          row_valid,
    output logic                               row_ready,
    input  wire grs_pkg::row_item_t            row_data,
    output logic                               styled_valid,
    input  wire logic                          styled_ready,
    output grs_pkg::styled_item_t              styled_data
);
    import grs_pkg::*;

    localparam int AW = $clog2(EMIT_DEPTH);
    localparam int CW = $clog2(EMIT_DEPTH + 1);

    logic [STYLE_W-1:0] style_reg;
    logic               turkish_reg;

    logic [BITS_W-1:0]  held_base_reg;
    logic [BITS_W-1:0]  before_held_base_reg;
    logic [GLYPH_W-1:0] held_glyph_reg;
    logic [ROW_W-1:0]   held_row_reg;
    logic               held_valid_reg;

    emit_t              emit_q_reg [EMIT_DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW-1:0]      rd_ptr_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    logic               accept;
    logic               is_last_row;
    logic [BITS_W-1:0]  prev_base;
    emit_t              held_rec;
    emit_t              tail_rec;
    emit_t              first_rec;
    logic [1:0]         push_cnt;
    logic               emit_valid;
    logic               emit_ready;
    logic               pop;

    always_comb
    begin
        accept      = row_valid && row_ready;
        is_last_row = row_data.row_index == LAST_ROW;
        prev_base   = held_valid_reg ? held_base_reg : '0;

        held_rec.glyph = held_glyph_reg;
        held_rec.row   = held_row_reg;
        held_rec.bits  = style_row(style_reg, held_row_reg, held_base_reg,
                                   before_held_base_reg, row_data.row_bits);
        held_rec.last  = !is_last_row;

        tail_rec.glyph = row_data.glyph_code;
        tail_rec.row   = row_data.row_index;
        tail_rec.bits  = style_row(style_reg, row_data.row_index, row_data.row_bits,
                                   prev_base, 8'h00);
        tail_rec.last  = 1'b1;

        first_rec = held_valid_reg ? held_rec : tail_rec;
        push_cnt  = accept ? ({1'b0, held_valid_reg} + {1'b0, is_last_row}) : 2'd0;

        emit_valid = count_reg != '0;
        pop        = emit_valid && emit_ready;

        wr_ptr_next = wr_ptr_reg + AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
    end

    assign row_ready = count_reg <= CW'(EMIT_DEPTH - 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            style_reg   <= STYLE_DEFAULT;
            turkish_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STYLE:   style_reg   <= cfg_data;
                REG_TURKISH: turkish_reg <= cfg_data[0];
                default:     style_reg   <= style_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg       <= 1'b0;
            held_base_reg        <= '0;
            before_held_base_reg <= '0;
            held_glyph_reg       <= '0;
            held_row_reg         <= '0;
        end
        else if (accept)
        begin
            if (is_last_row)
                held_valid_reg <= 1'b0;
            else
            begin
                held_valid_reg       <= 1'b1;
                held_base_reg        <= row_data.row_bits;
                before_held_base_reg <= prev_base;
                held_glyph_reg       <= row_data.glyph_code;
                held_row_reg         <= row_data.row_index;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            emit_q_reg[wr_ptr_reg] <= first_rec;
        if (push_cnt == 2'd2)
            emit_q_reg[wr_ptr_reg + AW'(1)] <= tail_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    grs_accent_stage u_accent (
        .clk            (clk),
        .rst_n          (rst_n),
        .turkish_enable (turkish_reg),
        .emit_valid     (emit_valid),
        .emit_rec       (emit_q_reg[rd_ptr_reg]),
        .emit_ready     (emit_ready),
        .styled_valid   (styled_valid),
        .styled_ready   (styled_ready),
        .styled_data    (styled_data)
    );

endmodule
`default_nettype wire

>>> hw/rtl/grs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grs_checker
// Port-level checks of the glyph row styler: output hold under stall, the last
// mark of row 15 results and ordering of the two results of a row 15 transfer.
// ----------------------------------------------------------------------------
module grs_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          styled_valid,
    input wire logic                          styled_ready,
    input wire grs_pkg::styled_item_t         styled_data
);
    import grs_pkg::*;

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        styled_valid && !styled_ready |=> styled_valid && $stable(styled_data))
        else $error("styled output changed while stalled");

    a_row15_last: assert property (@(posedge clk) disable iff (!rst_n)
        styled_valid |-> (styled_data.out_row != LAST_ROW) || styled_data.run_last)
        else $error("last-row result not marked as last");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        styled_valid && styled_ready && !styled_data.run_last
        |=> styled_valid && styled_data.run_last && (styled_data.out_row == LAST_ROW))
        else $error("held row not followed by its last-row partner");

    a_not_last_not15: assert property (@(posedge clk) disable iff (!rst_n)
        styled_valid && !styled_data.run_last |-> styled_data.out_row != LAST_ROW)
        else $error("non-last result carries the last row");

endmodule

bind glyph_row_styler grs_checker u_grs_checker (.*);
`default_nettype wire

>>> tb/sv/glyph_row_styler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_row_styler_tb
// Streams base font rows through the styler and scores every styled row
// against an in-bench model of the row hold, the ten styles and the accent
// build. Directed rows hit the neighbor styles, marked rows, unused style
// codes and each accent kind; random phases sweep every style with whole
// glyphs, cut glyphs and stray rows under random gaps and output stalls.
// ----------------------------------------------------------------------------
module glyph_row_styler_tb;

    import grs_pkg::*;

    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 20;
    localparam int PHASE_ROWS    = 100;

    localparam logic [STYLE_W-1:0] STYLE_UNUSED_TOP = 4'd15;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                cfg_we       = 1'b0;
    logic [0:0]          cfg_index    = '0;
    logic [CFG_W-1:0]    cfg_data     = '0;
    logic                row_valid    = 1'b0;
    logic                row_ready;
    row_item_t           row_data     = '0;
    logic                styled_valid;
    logic                styled_ready = 1'b0;
    styled_item_t        styled_data;

    // model state
    logic [STYLE_W-1:0]  cur_style   = STYLE_DEFAULT;
    logic                cur_turkish = 1'b0;
    logic [BITS_W-1:0]   held_bits   = '0;
    logic [BITS_W-1:0]   held_prev   = '0;
    logic [GLYPH_W-1:0]  held_glyph  = '0;
    logic [ROW_W-1:0]    held_row    = '0;
    logic                held_ok     = 1'b0;
    logic [BITS_W-1:0]   accent_store [ACCENT_GLYPHS][ROWS_PER_GLYPH];
    bit                  source_seen  [ACCENT_GLYPHS][ROWS_PER_GLYPH];

    styled_item_t        pending_rows [$];

    int                  fail_count    = 0;
    int                  rows_sent     = 0;
    int                  rows_checked  = 0;
    int                  hold_requests = 0;
    bit                  no_idle       = 1'b0;

    glyph_row_styler DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .row_valid    (row_valid),
        .row_ready    (row_ready),
        .row_data     (row_data),
        .styled_valid (styled_valid),
        .styled_ready (styled_ready),
        .styled_data  (styled_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BITS_W-1:0] rand_bits();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [GLYPH_W-1:0] pick_glyph();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return SRC_CODE[$urandom_range(0, ACCENT_GLYPHS - 1)];
        if (pick < 6)
            return DST_CODE[$urandom_range(0, ACCENT_GLYPHS - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [BITS_W-1:0] shape_row(
        input logic [ROW_W-1:0]  r,
        input logic [BITS_W-1:0] b,
        input logic [BITS_W-1:0] prev,
        input logic [BITS_W-1:0] next
    );
        logic [BITS_W-1:0] v;
        case (cur_style)
            STYLE_BOLD:      v = b | (b >> 1);
            STYLE_NARROW:    v = b & 8'hFE;
            STYLE_ITALIC:    v = (r < 4) ? (b >> 1) : ((r >= 12) ? (b << 1) : b);
            STYLE_UNDERLINE: v = (r == 4'd14) ? 8'hFF : b;
            STYLE_STRIKE:    v = (r == 4'd8) ? 8'hFF : b;
            STYLE_WIDE:      v = b | (b >> 1) | (b << 1);
            STYLE_OUTLINE:   v = b & ~(b << 1) & ~(b >> 1);
            STYLE_SHADOW:    v = b | ((r != 4'd0) ? (prev >> 1) : 8'h00);
            STYLE_RETRO:     v = b | ((r != LAST_ROW) ? next : 8'h00) | (b >> 1);
            default:         v = b;
        endcase
        return v;
    endfunction

    function automatic logic [BITS_W-1:0] accent_row(
        input patch_kind_t       kind,
        input logic [ROW_W-1:0]  r,
        input logic [BITS_W-1:0] v
    );
        case (kind)
            PATCH_CEDILLA:
            begin
                if (r == 4'd13)
                    return 8'h0C;
                if (r == 4'd14)
                    return 8'h18;
            end
            PATCH_BREVE:
            begin
                if (r == 4'd1)
                    return 8'h66;
                if (r == 4'd2)
                    return 8'h00;
            end
            PATCH_DOTLESS:
            begin
                if (r == 4'd2)
                    return 8'h00;
            end
            PATCH_DOT:
            begin
                if (r == 4'd1)
                    return 8'h18;
                if (r == 4'd2)
                    return 8'h00;
            end
            default:
            begin
                if (r == 4'd1)
                    return 8'h24;
                if (r == 4'd2)
                    return 8'h00;
            end
        endcase
        return v;
    endfunction

    function automatic styled_item_t styled_from(
        input logic [GLYPH_W-1:0] g,
        input logic [ROW_W-1:0]   r,
        input logic [BITS_W-1:0]  b,
        input logic [BITS_W-1:0]  prev,
        input logic [BITS_W-1:0]  next
    );
        styled_item_t res;
        logic [BITS_W-1:0] v;
        v = shape_row(r, b, prev, next);
        for (int i = 0; i < ACCENT_GLYPHS; i++)
        begin
            if (g == SRC_CODE[i])
                accent_store[i][r] = v;
            if (cur_turkish && g == DST_CODE[i])
                v = accent_row(PATCH_KIND[i], r, accent_store[i][r]);
        end
        res.out_glyph = g;
        res.out_row   = r;
        res.out_bits  = v;
        res.run_last  = 1'b0;
        return res;
    endfunction

    task automatic restyle_transfer(input row_item_t it);
        styled_item_t released;
        styled_item_t closing;
        logic [BITS_W-1:0] prev;
        bit has_released;
        prev = held_ok ? held_bits : 8'h00;
        has_released = held_ok;
        if (held_ok)
            released = styled_from(held_glyph, held_row, held_bits, held_prev, it.row_bits);
        if (it.row_index == LAST_ROW)
        begin
            closing = styled_from(it.glyph_code, it.row_index, it.row_bits, prev, 8'h00);
            closing.run_last = 1'b1;
            if (has_released)
                pending_rows.push_back(released);
            pending_rows.push_back(closing);
            held_ok = 1'b0;
        end
        else
        begin
            if (has_released)
            begin
                released.run_last = 1'b1;
                pending_rows.push_back(released);
            end
            held_prev  = prev;
            held_bits  = it.row_bits;
            held_glyph = it.glyph_code;
            held_row   = it.row_index;
            held_ok    = 1'b1;
        end
    endtask

    task automatic send_row(
        input logic [GLYPH_W-1:0] g,
        input logic [ROW_W-1:0]   r,
        input logic [BITS_W-1:0]  b
    );
        row_item_t it;
        int gap;
        it.glyph_code = g;
        it.row_index  = r;
        it.row_bits   = b;
        // a target row may only be built once its source row is stored
        for (int i = 0; i < ACCENT_GLYPHS; i++)
        begin
            if (cur_turkish && it.glyph_code == DST_CODE[i] && !source_seen[i][r])
                it.glyph_code = SRC_CODE[i];
        end
        for (int i = 0; i < ACCENT_GLYPHS; i++)
        begin
            if (it.glyph_code == SRC_CODE[i])
                source_seen[i][r] = 1'b1;
        end
        gap = no_idle ? 0 : gap_len();
        if (gap > 0)
        begin
            row_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        row_valid <= 1'b1;
        row_data  <= it;
        do
            @(posedge clk);
        while (!row_ready);
        rows_sent++;
        restyle_transfer(it);
    endtask

    task automatic send_glyph(input logic [GLYPH_W-1:0] g, input int lo_row, input int hi_row);
        for (int r = lo_row; r <= hi_row; r++)
            send_row(g, 4'(r), rand_bits());
    endtask

    task automatic wait_for_results();
        row_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rows.size() != 0);
    endtask

    // flush any held row so the block is idle before a register write
    task automatic settle();
        if (held_ok)
            send_row(8'h00, LAST_ROW, rand_bits());
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_STYLE)
            cur_style = val;
        else
            cur_turkish = val[0];
    endtask

    task automatic test_neighbor_styles();
        write_reg(REG_STYLE, STYLE_RETRO);
        send_row(8'h00, LAST_ROW, 8'hFF);
        send_row(8'hFF, 4'd0, 8'h80);
        send_row(8'hFF, 4'd14, 8'h01);
        send_row(8'hFF, LAST_ROW, 8'hFF);
        settle();
        write_reg(REG_STYLE, STYLE_SHADOW);
        send_row(8'h01, 4'd0, 8'hFF);
        send_row(8'h01, 4'd1, 8'h00);
        send_row(8'h01, 4'd0, 8'h7E);
        send_row(8'h01, LAST_ROW, 8'h81);
        settle();
    endtask

    task automatic test_marked_rows();
        write_reg(REG_STYLE, STYLE_UNDERLINE);
        send_row(8'h02, 4'd14, 8'h00);
        send_row(8'h02, LAST_ROW, 8'h00);
        settle();
        write_reg(REG_STYLE, STYLE_STRIKE);
        send_row(8'h03, 4'd8, 8'h00);
        send_row(8'h03, LAST_ROW, 8'h00);
        settle();
    endtask

    task automatic test_style_sweep();
        for (int s = 0; s <= 10; s++)
        begin
            write_reg(REG_STYLE, 4'(s));
            send_row(8'(8'h30 + s), LAST_ROW, 8'hA5);
            settle();
        end
        write_reg(REG_STYLE, STYLE_UNUSED_TOP);
        send_row(8'h04, 4'd3, 8'hA5);
        send_row(8'h04, LAST_ROW, 8'h5A);
        settle();
    endtask

    task automatic test_accent_build();
        write_reg(REG_STYLE, STYLE_ITALIC);
        write_reg(REG_TURKISH, CFG_W'(1));
        send_row(SRC_CODE[0], 4'd13, 8'hFF);
        send_row(DST_CODE[0], 4'd13, 8'h00);
        send_row(SRC_CODE[2], 4'd1, 8'hFF);
        send_row(DST_CODE[2], 4'd1, 8'h00);
        send_row(SRC_CODE[4], 4'd2, 8'hFF);
        send_row(DST_CODE[4], 4'd2, 8'h00);
        send_row(SRC_CODE[5], 4'd1, 8'h3C);
        send_row(DST_CODE[5], 4'd1, 8'h00);
        send_row(SRC_CODE[6], 4'd1, 8'h81);
        send_row(DST_CODE[6], 4'd1, 8'h00);
        settle();
        write_reg(REG_TURKISH, CFG_W'(0));
    endtask

    task automatic test_output_stall();
        hold_requests++;
        no_idle = 1'b1;
        for (int n = 0; n < 3; n++)
            send_glyph(pick_glyph(), 0, 15);
        no_idle = 1'b0;
        settle();
    endtask

    task automatic test_mid_glyph_pause();
        logic [GLYPH_W-1:0] g;
        g = pick_glyph();
        send_glyph(g, 0, 7);
        wait_for_results();
        send_glyph(g, 8, 15);
        settle();
    endtask

    task automatic test_random_font();
        int start;
        int kind;
        int lo_row;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_reg(REG_STYLE, 4'(phase % 16));
            write_reg(REG_TURKISH, CFG_W'($urandom_range(0, 1)));
            no_idle = (phase % 5 == 4);
            start = rows_sent;
            while (rows_sent - start < PHASE_ROWS)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 8)
                    send_glyph(pick_glyph(), 0, 15);
                else if (kind == 8)
                begin
                    lo_row = $urandom_range(0, 7);
                    send_glyph(pick_glyph(), lo_row, lo_row + $urandom_range(0, 8));
                end
                else
                begin
                    repeat (4)
                        send_row(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                                 8'($urandom_range(0, 255)));
                end
            end
            no_idle = 1'b0;
            settle();
        end
    endtask

    initial
    begin
        int stall;
        int holds_served;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                styled_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = no_idle ? 0 : gap_len();
            if (stall > 0)
            begin
                styled_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            styled_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        styled_item_t want;
        if (rst_n && styled_valid && styled_ready)
        begin
            if (pending_rows.size() == 0)
            begin
                $error("styled row transfer with nothing expected: %h", styled_data);
                fail_count++;
            end
            else
            begin
                want = pending_rows.pop_front();
                check_field("out_glyph", want.out_glyph, styled_data.out_glyph);
                check_field("out_row", want.out_row, styled_data.out_row);
                check_field("out_bits", want.out_bits, styled_data.out_bits);
                check_field("run_last", want.run_last, styled_data.run_last);
                rows_checked++;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_neighbor_styles();
        test_marked_rows();
        test_style_sweep();
        test_accent_build();
        test_output_stall();
        test_mid_glyph_pause();
        test_random_font();
        settle();
        $display("Sent %0d font rows and checked %0d styled rows over every style code,",
                 rows_sent, rows_checked);
        $display("with the accent build on and off, output stalls and input pauses.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
